// ===== design/mbd_pkg.sv =====
package mbd_pkg;

    localparam int SAMPLE_BITS  = 16;
    localparam int SUM_BITS     = 24;
    localparam int SLOT_BITS    = 5;
    localparam int CHAN_BITS    = 6;
    localparam int FACTOR_BITS  = 9;
    localparam int PHASE_BITS   = 8;
    localparam int MAX_CHANNELS = 32;
    localparam int MAX_FACTOR   = 256;
    localparam int DIV_STEPS    = SUM_BITS;
    localparam int DIV_CNT_BITS = $clog2(DIV_STEPS);

    localparam logic REG_FACTOR   = 1'b0;
    localparam logic REG_CHANNELS = 1'b1;

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_CALC = 4'b0010,
        ST_DIV  = 4'b0100,
        ST_DONE = 4'b1000
    } t_state;

    typedef struct packed {
        logic busy;
        logic done;
    } t_div_status;

endpackage

// ===== design/mbd_divider.sv =====
module mbd_divider (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_start,
    input  logic [mbd_pkg::SUM_BITS-1:0]        i_dividend,
    input  logic [mbd_pkg::FACTOR_BITS-1:0]     i_divisor,
    output mbd_pkg::t_div_status                o_status,
    output logic [mbd_pkg::SUM_BITS-1:0]        o_quotient
);

    logic                                r_busy;
    logic                                r_done;
    logic [mbd_pkg::DIV_CNT_BITS-1:0]    r_cnt;
    logic [mbd_pkg::FACTOR_BITS-1:0]     r_rem;
    logic [mbd_pkg::SUM_BITS-1:0]        r_quo;
    logic [mbd_pkg::FACTOR_BITS-1:0]     r_div;

    logic [mbd_pkg::FACTOR_BITS:0]       w_trial;
    logic [mbd_pkg::FACTOR_BITS:0]       w_diff;
    logic                                w_fits;

    always_comb begin
        w_trial = {r_rem, r_quo[mbd_pkg::SUM_BITS-1]};
        w_fits  = (w_trial >= {1'b0, r_div});
        w_diff  = w_trial - {1'b0, r_div};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= mbd_pkg::DIV_CNT_BITS'(mbd_pkg::DIV_STEPS - 1);
            end else if (r_busy) begin
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_cnt <= r_cnt - mbd_pkg::DIV_CNT_BITS'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= i_dividend;
            r_div <= i_divisor;
        end else if (r_busy) begin
            r_quo <= {r_quo[mbd_pkg::SUM_BITS-2:0], w_fits};
            r_rem <= w_fits ? w_diff[mbd_pkg::FACTOR_BITS-1:0]
                            : w_trial[mbd_pkg::FACTOR_BITS-1:0];
        end
    end

    assign o_status.busy = r_busy;
    assign o_status.done = r_done;
    assign o_quotient    = r_quo;

endmodule

// ===== design/multichannel_boxcar_decimator_unit.sv =====
// Boxcar decimator for round-robin multichannel converter samples. Each accepted
// beat is added to its channel's running sum; in the last frame of every run of
// supersample_factor frames the channel's truncated mean is sent and its sum
// cleared. With a factor of 1 samples pass straight through, tagged with their
// slot. The input is taken one beat at a time: a beat passes its calculate state,
// then for a result the done state, an averaging beat first waiting in the divide
// state on the shared restoring divider that resolves one quotient bit per cycle
// over the 24-bit sum; only then is the next beat taken. A register write or a
// start-of-run flag clears all sums and counters at once. A finished result waits
// in the output register while the next beat is taken.
module multichannel_boxcar_decimator_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    // [15:0] sample
    input  logic [15:0] i_s_axis_tdata,
    // [0] start_of_run
    input  logic        i_s_axis_tuser,
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    // [15:0] average
    output logic [15:0] o_m_axis_tdata,
    // [4:0] channel_slot
    output logic [4:0]  o_m_axis_tuser,
    input  logic        i_cfg_wr_en,
    input  logic        i_cfg_index,
    input  logic [8:0]  i_cfg_data
);

    localparam int SB = mbd_pkg::SAMPLE_BITS;
    localparam int UB = mbd_pkg::SUM_BITS;
    localparam int LB = mbd_pkg::SLOT_BITS;
    localparam int CB = mbd_pkg::CHAN_BITS;
    localparam int FB = mbd_pkg::FACTOR_BITS;
    localparam int PB = mbd_pkg::PHASE_BITS;

    mbd_pkg::t_state           r_state;
    logic [FB-1:0]             r_factor;
    logic [CB-1:0]             r_channels;
    logic [LB-1:0]             r_slot;
    logic [PB-1:0]             r_phase;
    logic [UB-1:0]             r_sums [mbd_pkg::MAX_CHANNELS];
    logic [SB-1:0]             r_sample;
    logic                      r_sor;
    logic                      r_pass;
    logic [LB-1:0]             r_res_slot;
    logic                      r_div_start;
    logic [UB-1:0]             r_div_dividend;
    logic                      r_out_valid;
    logic [SB-1:0]             r_out_avg;
    logic [LB-1:0]             r_out_slot;

    logic [FB-1:0]             w_factor;
    logic [CB-1:0]             w_nch;
    logic [LB-1:0]             w_slot;
    logic [PB-1:0]             w_phase;
    logic [UB-1:0]             w_old;
    logic [UB-1:0]             w_new;
    logic                      w_pass;
    logic                      w_last;
    logic                      w_wrap;
    logic [LB-1:0]             n_slot;
    logic [PB-1:0]             n_phase;

    mbd_pkg::t_div_status      w_div_status;
    logic [UB-1:0]             w_quotient;

    mbd_divider u_divider (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (r_div_start),
        .i_dividend (r_div_dividend),
        .i_divisor  (w_factor),
        .o_status   (w_div_status),
        .o_quotient (w_quotient)
    );

    always_comb begin
        if (r_factor == '0) begin
            w_factor = FB'(1);
        end else if (r_factor > FB'(mbd_pkg::MAX_FACTOR)) begin
            w_factor = FB'(mbd_pkg::MAX_FACTOR);
        end else begin
            w_factor = r_factor;
        end

        if (r_channels == '0) begin
            w_nch = CB'(1);
        end else if (r_channels > CB'(mbd_pkg::MAX_CHANNELS)) begin
            w_nch = CB'(mbd_pkg::MAX_CHANNELS);
        end else begin
            w_nch = r_channels;
        end

        if (r_sor || ({1'b0, r_slot} >= w_nch)) begin
            w_slot = '0;
        end else begin
            w_slot = r_slot;
        end

        if (r_sor || ({1'b0, r_phase} >= w_factor)) begin
            w_phase = '0;
        end else begin
            w_phase = r_phase;
        end

        w_old  = r_sor ? '0 : r_sums[w_slot];
        w_new  = w_old + UB'(r_sample);
        w_pass = (w_factor == FB'(1));
        w_last = ({1'b0, w_phase} == (w_factor - FB'(1)));
        w_wrap = (({1'b0, w_slot} + CB'(1)) >= w_nch);

        if (w_wrap) begin
            n_slot = '0;
            if (({1'b0, w_phase} + FB'(1)) >= w_factor) begin
                n_phase = '0;
            end else begin
                n_phase = w_phase + PB'(1);
            end
        end else begin
            n_slot  = w_slot + LB'(1);
            n_phase = w_phase;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= mbd_pkg::ST_IDLE;
            r_factor    <= FB'(1);
            r_channels  <= CB'(1);
            r_slot      <= '0;
            r_phase     <= '0;
            r_div_start <= 1'b0;
            r_out_valid <= 1'b0;
            for (int i = 0; i < mbd_pkg::MAX_CHANNELS; i++) begin
                r_sums[i] <= '0;
            end
        end else begin
            r_div_start <= 1'b0;
            if (r_out_valid && i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                mbd_pkg::ST_IDLE: begin
                    if (i_cfg_wr_en) begin
                        if (i_cfg_index == mbd_pkg::REG_FACTOR) begin
                            r_factor <= i_cfg_data;
                        end else begin
                            r_channels <= i_cfg_data[CB-1:0];
                        end
                        r_slot  <= '0;
                        r_phase <= '0;
                        for (int i = 0; i < mbd_pkg::MAX_CHANNELS; i++) begin
                            r_sums[i] <= '0;
                        end
                    end
                    if (i_s_axis_tvalid) begin
                        r_sample <= i_s_axis_tdata;
                        r_sor    <= i_s_axis_tuser;
                        r_state  <= mbd_pkg::ST_CALC;
                    end
                end
                mbd_pkg::ST_CALC: begin
                    if (r_sor) begin
                        for (int i = 0; i < mbd_pkg::MAX_CHANNELS; i++) begin
                            r_sums[i] <= '0;
                        end
                    end
                    r_slot     <= n_slot;
                    r_phase    <= n_phase;
                    r_res_slot <= w_slot;
                    r_pass     <= w_pass;
                    if (w_pass) begin
                        r_state <= mbd_pkg::ST_DONE;
                    end else if (w_last) begin
                        r_sums[w_slot] <= '0;
                        r_div_dividend <= w_new;
                        r_div_start    <= 1'b1;
                        r_state        <= mbd_pkg::ST_DIV;
                    end else begin
                        r_sums[w_slot] <= w_new;
                        r_state        <= mbd_pkg::ST_IDLE;
                    end
                end
                mbd_pkg::ST_DIV: begin
                    if (w_div_status.done && !w_div_status.busy) begin
                        r_state <= mbd_pkg::ST_DONE;
                    end
                end
                mbd_pkg::ST_DONE: begin
                    if (!r_out_valid || i_m_axis_tready) begin
                        r_out_valid <= 1'b1;
                        r_out_avg   <= r_pass ? r_sample : w_quotient[SB-1:0];
                        r_out_slot  <= r_res_slot;
                        r_state     <= mbd_pkg::ST_IDLE;
                    end
                end
                default: begin
                    r_state <= mbd_pkg::ST_IDLE;
                end
            endcase
        end
    end

    assign o_s_axis_tready = (r_state == mbd_pkg::ST_IDLE);
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_avg;
    assign o_m_axis_tuser  = r_out_slot;

endmodule

// ===== verif/tb.sv =====
`timescale 1ns / 100ps

module tb;
    import mbd_pkg::*;

    localparam int CLK_PERIOD    = 12;
    localparam int SETTLE_CYCLES = 40;
    localparam int RANDOM_ITEMS  = 1350;
    localparam int TIMEOUT_NS    = 10_000_000;

    typedef struct packed {
        logic [SAMPLE_BITS-1:0] average;
        logic [SLOT_BITS-1:0]   channel_slot;
    } t_avg_result;

    typedef enum logic [1:0] {
        READY_ALWAYS,
        READY_COIN,
        READY_SPARSE,
        READY_PERIODIC
    } t_ready_mode;

    logic                   i_clk     = 1'b0;
    logic                   i_rst_n   = 1'b0;
    logic                   s_valid   = 1'b0;
    logic [SAMPLE_BITS-1:0] s_data    = '0;
    logic                   s_user    = 1'b0;
    logic                   s_ready;
    logic                   m_valid;
    logic                   m_ready   = 1'b0;
    logic [SAMPLE_BITS-1:0] m_data;
    logic [SLOT_BITS-1:0]   m_user;
    logic                   cfg_wr_en = 1'b0;
    logic                   cfg_index = REG_FACTOR;
    logic [FACTOR_BITS-1:0] cfg_data  = '0;

    // Predictor state.
    logic [FACTOR_BITS-1:0] factor_reg;
    logic [CHAN_BITS-1:0]   channels_reg;
    logic [SUM_BITS-1:0]    running_sums [MAX_CHANNELS];
    int unsigned            slot_pos;
    int unsigned            frame_pos;
    t_avg_result            pending_avgs [$];

    int          error_count  = 0;
    int          burst_left   = 0;
    t_ready_mode ready_mode   = READY_ALWAYS;
    int          mode_left    = 0;
    int unsigned ready_tick   = 0;

    multichannel_boxcar_decimator_unit uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_valid),
        .o_s_axis_tready (s_ready),
        .i_s_axis_tdata  (s_data),
        .i_s_axis_tuser  (s_user),
        .o_m_axis_tvalid (m_valid),
        .i_m_axis_tready (m_ready),
        .o_m_axis_tdata  (m_data),
        .o_m_axis_tuser  (m_user),
        .i_cfg_wr_en     (cfg_wr_en),
        .i_cfg_index     (cfg_index),
        .i_cfg_data      (cfg_data)
    );

    initial begin
        forever #(CLK_PERIOD / 2) i_clk = ~i_clk;
    end

    initial begin
        #(TIMEOUT_NS);
        $display("RESULT: ERROR");
        $finish;
    end

    function automatic void clear_sums();
        foreach (running_sums[i]) running_sums[i] = '0;
        slot_pos  = 0;
        frame_pos = 0;
    endfunction

    function automatic void predict_beat(logic [SAMPLE_BITS-1:0] smp, logic sor);
        int unsigned         fac;
        int unsigned         nch;
        int unsigned         slot;
        logic [SUM_BITS-1:0] total;
        if (sor) clear_sums();
        fac  = (factor_reg == 0) ? 1 :
               (factor_reg > MAX_FACTOR) ? MAX_FACTOR : 32'(factor_reg);
        nch  = (channels_reg == 0) ? 1 :
               (channels_reg > MAX_CHANNELS) ? MAX_CHANNELS : 32'(channels_reg);
        slot = (slot_pos >= nch) ? 0 : slot_pos;
        if (frame_pos >= fac) frame_pos = 0;
        if (fac == 1) begin
            pending_avgs.push_back('{average: smp, channel_slot: SLOT_BITS'(slot)});
        end else begin
            total = running_sums[slot] + SUM_BITS'(smp);
            if (frame_pos == fac - 1) begin
                pending_avgs.push_back('{average: SAMPLE_BITS'(total / fac),
                                         channel_slot: SLOT_BITS'(slot)});
                total = '0;
            end
            running_sums[slot] = total;
        end
        if (slot + 1 >= nch) begin
            slot_pos  = 0;
            frame_pos = (frame_pos + 1 >= fac) ? 0 : frame_pos + 1;
        end else begin
            slot_pos = slot + 1;
        end
    endfunction

    // Each received beat is matched against the oldest predicted average.
    always @(posedge i_clk) begin
        t_avg_result want;
        if (i_rst_n && m_valid && m_ready) begin
            if (pending_avgs.size() == 0) begin
                $error("unexpected beat: average %0d channel_slot %0d", m_data, m_user);
                error_count++;
            end else begin
                want = pending_avgs.pop_front();
                if (m_data !== want.average) begin
                    $error("average: expected %0d, actual %0d", want.average, m_data);
                    error_count++;
                end
                if (m_user !== want.channel_slot) begin
                    $error("channel_slot: expected %0d, actual %0d",
                           want.channel_slot, m_user);
                    error_count++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (mode_left == 0) begin
            ready_mode = t_ready_mode'($urandom_range(0, 3));
            mode_left  = $urandom_range(30, 300);
        end
        mode_left--;
        ready_tick++;
        case (ready_mode)
            READY_ALWAYS: m_ready <= 1'b1;
            READY_COIN:   m_ready <= ($urandom_range(0, 1) == 1);
            READY_SPARSE: m_ready <= ($urandom_range(0, 7) == 0);
            default:      m_ready <= ((ready_tick % 11) < 4);
        endcase
    end

    task automatic send_sample(input logic [SAMPLE_BITS-1:0] smp, input logic sor);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? $urandom_range(8, 40) : $urandom_range(0, 4);
            if ($urandom_range(0, 5) == 0) gap = 0;
            if (gap > 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120) :
                                                       $urandom_range(1, 12);
        end
        s_valid <= 1'b1;
        s_data  <= smp;
        s_user  <= sor;
        do @(posedge i_clk); while (!s_ready);
        predict_beat(smp, sor);
        burst_left--;
    endtask

    task automatic wait_drained();
        s_valid    <= 1'b0;
        burst_left = 0;
        while (pending_avgs.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_register(input logic idx, input logic [FACTOR_BITS-1:0] value);
        wait_drained();
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge i_clk);
        cfg_wr_en <= 1'b0;
        if (idx == REG_FACTOR) factor_reg = value;
        else channels_reg = value[CHAN_BITS-1:0];
        clear_sums();
    endtask

    task automatic test_passthrough_at_reset();
        send_sample(16'h0000, 1'b0);
        send_sample(16'hFFFF, 1'b0);
        send_sample(16'h5555, 1'b0);
        send_sample(16'hAAAA, 1'b1);
    endtask

    task automatic test_factor_limits();
        write_register(REG_FACTOR, 9'd0);
        send_sample(16'h1234, 1'b0);
        write_register(REG_FACTOR, 9'd2);
        send_sample(16'hFFFF, 1'b0);
        send_sample(16'hFFFF, 1'b0);
        send_sample(16'h0000, 1'b0);
        send_sample(16'h0001, 1'b0);
    endtask

    task automatic test_channel_limits();
        write_register(REG_FACTOR, 9'd1);
        write_register(REG_CHANNELS, 9'd0);
        send_sample(16'h8001, 1'b0);
        send_sample(16'h7FFE, 1'b0);
    endtask

    task automatic test_start_of_run();
        write_register(REG_FACTOR, 9'd2);
        write_register(REG_CHANNELS, 9'd3);
        for (int k = 0; k < 9; k++) send_sample(SAMPLE_BITS'($urandom), k == 3);
    endtask

    task automatic test_write_clears();
        write_register(REG_CHANNELS, 9'd1);
        send_sample(16'hFFFF, 1'b0);
        write_register(REG_FACTOR, 9'd2);
        send_sample(16'h0002, 1'b0);
        send_sample(16'h0004, 1'b0);
    endtask

    task automatic test_random_runs();
        int unsigned            fac;
        int unsigned            nch;
        int unsigned            count;
        int unsigned            sent;
        int unsigned            phase;
        logic [FACTOR_BITS-1:0] fac_val;
        logic [CHAN_BITS-1:0]   ch_val;
        logic [SAMPLE_BITS-1:0] smp;
        sent  = 0;
        phase = 0;
        while (sent < RANDOM_ITEMS) begin
            if (phase == 1) begin
                fac_val = 9'h1FF;
                ch_val  = 6'd1;
            end else if (phase == 3) begin
                fac_val = 9'd1;
                ch_val  = 6'h3F;
            end else if (phase == 5) begin
                fac_val = 9'd256;
                ch_val  = 6'd1;
            end else if (phase == 7) begin
                fac_val = FACTOR_BITS'($urandom_range(2, 4));
                ch_val  = 6'd32;
            end else begin
                case ($urandom_range(0, 9))
                    0:       fac_val = 9'd0;
                    1, 2:    fac_val = 9'd1;
                    3:       fac_val = FACTOR_BITS'($urandom_range(9, 24));
                    default: fac_val = FACTOR_BITS'($urandom_range(2, 8));
                endcase
                case ($urandom_range(0, 9))
                    0:       ch_val = 6'd0;
                    1:       ch_val = CHAN_BITS'($urandom_range(33, 63));
                    2:       ch_val = CHAN_BITS'($urandom_range(9, 32));
                    default: ch_val = CHAN_BITS'($urandom_range(1, 8));
                endcase
            end
            if ($urandom_range(0, 1) == 0) begin
                write_register(REG_FACTOR, fac_val);
                write_register(REG_CHANNELS, 9'(ch_val));
            end else begin
                write_register(REG_CHANNELS, 9'(ch_val));
                write_register(REG_FACTOR, fac_val);
            end
            fac = (fac_val == 0) ? 1 : (fac_val > MAX_FACTOR) ? MAX_FACTOR : 32'(fac_val);
            nch = (ch_val == 0) ? 1 : (ch_val > MAX_CHANNELS) ? MAX_CHANNELS : 32'(ch_val);
            if (fac * nch > 64) count = fac * nch + $urandom_range(0, nch);
            else count = fac * nch * $urandom_range(1, 3) + $urandom_range(0, nch);
            if (count > RANDOM_ITEMS - sent) count = RANDOM_ITEMS - sent;
            for (int unsigned k = 0; k < count; k++) begin
                case ($urandom_range(0, 15))
                    0:       smp = 16'hFFFF;
                    1:       smp = 16'h0000;
                    default: smp = SAMPLE_BITS'($urandom);
                endcase
                if (phase == 1) smp = 16'hFFFF;
                send_sample(smp, (fac <= 24) && ($urandom_range(0, 59) == 0));
                if ($urandom_range(0, 299) == 0) wait_drained();
            end
            sent += count;
            phase++;
        end
    endtask

    initial begin
        factor_reg   = 9'd1;
        channels_reg = 6'd1;
        clear_sums();
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_passthrough_at_reset();
        test_factor_limits();
        test_channel_limits();
        test_start_of_run();
        test_write_clears();
        test_random_runs();
        wait_drained();
        if (error_count == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
